FILE: hdl/keyed_ordered_list_engine_assert.svh
// Assertion macros for the keyed ordered list engine.
// Define NO_ASSERTIONS to compile them away.
`ifndef KEYED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define KEYED_ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define KOLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check an implication on every clock edge outside reset.
`define KOLE_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define KOLE_ASSERT(lbl, prop, msg)
`define KOLE_ASSERT_IMP(lbl, pre, post, msg)
`endif

`endif

FILE: hdl/kole_pkg.sv
`timescale 1ns / 1ps
package kole_pkg;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_SEARCH    = 3'd2;
    localparam logic [2:0] CMD_DEL_KEY   = 3'd3;
    localparam logic [2:0] CMD_DEL_AFTER = 3'd4;
    localparam logic [2:0] CMD_READ_POS  = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_NO_SUCC   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [26:0] key;
        logic [31:0] payload;
        logic [5:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [26:0] found_key;
        logic [31:0] found_payload;
        logic [6:0]  entry_total;
    } t_out_item;

endpackage

FILE: hdl/keyed_ordered_list_engine.sv
`timescale 1ns / 1ps
// Keyed ordered list engine: a singly linked list of up to CAPACITY records
// (27-bit key, 32-bit payload) held in slot memories with registered reads.
// One command is taken at a time; o_in_stall stays high while it runs.
// Every link step is a memory read followed by a check; a search, delete or
// positional read walks the list from the head this way. An insert scans the
// slot-used memory for the lowest free slot, one read and check per slot,
// then writes the record and, when it appends to a non-empty list, links the
// old tail in a second write. After reset a clearing pass empties the
// slot-used memory before the first command is taken. The result sits in an
// output register, so a finished result may wait while the next command runs.
`include "keyed_ordered_list_engine_assert.svh"

module keyed_ordered_list_engine
    import kole_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int SW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_SCAN_RD  = 12'b0000_0000_0100,
        S_SCAN_CHK = 12'b0000_0000_1000,
        S_INS_WR   = 12'b0000_0001_0000,
        S_INS_LINK = 12'b0000_0010_0000,
        S_WALK_RD  = 12'b0000_0100_0000,
        S_WALK_CHK = 12'b0000_1000_0000,
        S_SUCC_RD  = 12'b0001_0000_0000,
        S_SUCC_CHK = 12'b0010_0000_0000,
        S_UNLINK   = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_cmd, n_cmd;
    logic [26:0]     r_key, n_key;
    logic [31:0]     r_pay, n_pay;
    logic [5:0]      r_pos, n_pos;
    logic [5:0]      r_step, n_step;
    logic [LW-1:0]   r_cur, n_cur;
    logic [LW-1:0]   r_prev, n_prev;
    logic [LW-1:0]   r_nlink, n_nlink;
    logic [LW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_tail, n_tail;
    logic [LW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_scan, n_scan;
    logic [SW-1:0]   r_clr, n_clr;
    t_out_item       r_res, n_res;
    t_out_item       r_out, n_out;
    logic            r_out_valid, n_out_valid;

    // Slot memories
    logic [26:0]     r_key_mem  [CAPACITY];
    logic [31:0]     r_pay_mem  [CAPACITY];
    logic [LW-1:0]   r_next_mem [CAPACITY];
    logic            r_used_mem [CAPACITY];
    logic [26:0]     r_rd_key;
    logic [31:0]     r_rd_pay;
    logic [LW-1:0]   r_rd_next;
    logic            r_rd_used;

    logic [SW-1:0]   rd_addr;
    logic            rec_we;
    logic [SW-1:0]   rec_waddr;
    logic            next_we;
    logic [SW-1:0]   next_waddr;
    logic [LW-1:0]   next_wdata;
    logic            used_we;
    logic [SW-1:0]   used_waddr;
    logic            used_wdata;
    logic            in_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Record memories: write on insert, read every cycle
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_key_mem[rec_waddr] <= r_key;
            r_pay_mem[rec_waddr] <= r_pay;
        end
        r_rd_key <= r_key_mem[rd_addr];
        r_rd_pay <= r_pay_mem[rd_addr];
    end

    // Link memory
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        r_rd_next <= r_next_mem[rd_addr];
    end

    // Slot-used memory
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_waddr] <= used_wdata;
        end
        r_rd_used <= r_used_mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_pay       = r_pay;
        n_pos       = r_pos;
        n_step      = r_step;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nlink     = r_nlink;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_scan      = r_scan;
        n_clr       = r_clr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rd_addr     = r_cur[SW-1:0];
        rec_we      = 1'b0;
        rec_waddr   = r_scan;
        next_we     = 1'b0;
        next_waddr  = r_scan;
        next_wdata  = NIL;
        used_we     = 1'b0;
        used_waddr  = r_scan;
        used_wdata  = 1'b0;

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                used_we    = 1'b1;
                used_waddr = r_clr;
                used_wdata = 1'b0;
                n_clr      = SW'(r_clr + 1'b1);
                if (r_clr == SW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd  = i_in.cmd;
                    n_key  = i_in.key;
                    n_pay  = i_in.payload;
                    n_pos  = i_in.position;
                    n_step = '0;
                    n_cur  = r_head;
                    n_prev = NIL;
                    n_scan = '0;
                    n_res  = '0;
                    n_res.status = ST_NOT_FOUND;
                    n_state = S_DONE;
                    unique case (i_in.cmd)
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            if (r_count == NIL) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_SEARCH, CMD_DEL_AFTER: begin
                            n_state = S_WALK_RD;
                        end
                        CMD_DEL_KEY: begin
                            if (r_head == NIL) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_WALK_RD;
                            end
                        end
                        CMD_READ_POS: begin
                            if (r_head == NIL) begin
                                n_res.status = ST_EMPTY;
                            end else if (32'(i_in.position) < 32'(r_count)) begin
                                n_state = S_WALK_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                rd_addr = r_scan;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // Take the first free slot, else advance
                if (!r_rd_used) begin
                    n_state = S_INS_WR;
                end else begin
                    n_scan  = SW'(r_scan + 1'b1);
                    n_state = S_SCAN_RD;
                end
            end
            S_INS_WR: begin
                rec_we     = 1'b1;
                used_we    = 1'b1;
                used_wdata = 1'b1;
                next_we    = 1'b1;
                n_res.status = ST_OK;
                if (r_cmd == CMD_INS_FRONT) begin
                    next_wdata = r_head;
                    n_head     = LW'(r_scan);
                    if (r_tail == NIL) begin
                        n_tail = LW'(r_scan);
                    end
                    n_count = LW'(r_count + 1'b1);
                    n_state = S_DONE;
                end else if (r_tail != NIL) begin
                    n_state = S_INS_LINK;
                end else begin
                    n_head  = LW'(r_scan);
                    n_tail  = LW'(r_scan);
                    n_count = LW'(r_count + 1'b1);
                    n_state = S_DONE;
                end
            end
            S_INS_LINK: begin
                next_we    = 1'b1;
                next_waddr = r_tail[SW-1:0];
                next_wdata = LW'(r_scan);
                n_tail     = LW'(r_scan);
                n_count    = LW'(r_count + 1'b1);
                n_state    = S_DONE;
            end
            S_WALK_RD: begin
                if (r_cur == NIL) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (r_cmd == CMD_READ_POS) begin
                    if (r_step == r_pos) begin
                        n_res.status        = ST_OK;
                        n_res.found_key     = r_rd_key;
                        n_res.found_payload = r_rd_pay;
                        n_state             = S_DONE;
                    end else begin
                        n_cur   = r_rd_next;
                        n_step  = 6'(r_step + 1'b1);
                        n_state = S_WALK_RD;
                    end
                end else if (r_rd_key == r_key) begin
                    if (r_cmd == CMD_DEL_AFTER) begin
                        if (r_rd_next == NIL) begin
                            n_res.status = ST_NO_SUCC;
                            n_state      = S_DONE;
                        end else begin
                            n_prev  = r_cur;
                            n_cur   = r_rd_next;
                            n_state = S_SUCC_RD;
                        end
                    end else begin
                        n_res.status        = ST_OK;
                        n_res.found_key     = r_rd_key;
                        n_res.found_payload = r_rd_pay;
                        n_nlink             = r_rd_next;
                        n_state = (r_cmd == CMD_DEL_KEY) ? S_UNLINK : S_DONE;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_rd_next;
                    n_state = S_WALK_RD;
                end
            end
            S_SUCC_RD: begin
                n_state = S_SUCC_CHK;
            end
            S_SUCC_CHK: begin
                n_res.status        = ST_OK;
                n_res.found_key     = r_rd_key;
                n_res.found_payload = r_rd_pay;
                n_nlink             = r_rd_next;
                n_state             = S_UNLINK;
            end
            S_UNLINK: begin
                // Bypass the removed slot and release it
                if (r_prev != NIL) begin
                    next_we    = 1'b1;
                    next_waddr = r_prev[SW-1:0];
                    next_wdata = r_nlink;
                end else begin
                    n_head = r_nlink;
                end
                if (r_tail == r_cur) begin
                    n_tail = r_prev;
                end
                used_we    = 1'b1;
                used_waddr = r_cur[SW-1:0];
                used_wdata = 1'b0;
                n_count    = LW'(r_count - 1'b1);
                n_state    = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out             = r_res;
                    n_out.entry_total = 7'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_nlink <= n_nlink;
        r_scan  <= n_scan;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    `KOLE_ASSERT(a_count_bound, r_count <= NIL, "record count above capacity")
    `KOLE_ASSERT(a_head_count, (r_head == NIL) == (r_count == '0), "head and count disagree")
    `KOLE_ASSERT(a_head_tail, (r_head == NIL) == (r_tail == NIL), "head and tail disagree")
    `KOLE_ASSERT_IMP(a_ins_room, r_state == S_INS_WR, r_count != NIL, "insert into full list")

endmodule
